FILE: sv/tth_pkg.sv
// Package for the text tokenizer with djb2 hashing.
// Holds the transaction types, the queue entry type and fixed constants.
// No dependencies.
package tth_pkg;

  // Input transaction: one text byte and the end-of-text flag.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } tth_in_t;

  // Result transaction: one finished token.
  typedef struct packed {
    logic [31:0] token_hash;
    logic [11:0] bucket_index;
    logic [7:0]  token_length;
    logic [31:0] token_position;
  } tth_out_t;

  // Classified byte, as queued between front and back.
  typedef struct packed {
    logic       is_word;
    logic [7:0] ch;
    logic       last;
  } tth_char_t;

  localparam logic [31:0] HASH_SEED   = 32'd5381;
  localparam int unsigned HASH_SHIFT  = 5;
  localparam logic [7:0]  MAX_LEN     = 8'd128;
  localparam int unsigned NUM_BUCKETS = 4096;
  localparam logic [31:0] BUCKET_MASK = 32'(NUM_BUCKETS - 1);

  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5A;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

endpackage

FILE: sv/tth_front.sv
// Front end: classifies each incoming byte as word or separator and lowercases it.
// Depends on tth_pkg.
module tth_front (
  input  tth_pkg::tth_in_t   in_data,
  output tth_pkg::tth_char_t char_out
);

  logic       is_digit;
  logic       is_upper;
  logic       is_lower;

  always_comb begin
    is_digit = in_data.text_byte inside {[tth_pkg::CH_DIGIT_LO : tth_pkg::CH_DIGIT_HI]};
    is_upper = in_data.text_byte inside {[tth_pkg::CH_UPPER_LO : tth_pkg::CH_UPPER_HI]};
    is_lower = in_data.text_byte inside {[tth_pkg::CH_LOWER_LO : tth_pkg::CH_LOWER_HI]};
  end

  always_comb begin
    char_out.is_word = is_digit | is_upper | is_lower;
    char_out.ch      = is_upper ? in_data.text_byte + tth_pkg::CASE_OFFSET
                                : in_data.text_byte;
    char_out.last    = in_data.text_end;
  end

endmodule

FILE: sv/tth_queue.sv
// Short FIFO of classified bytes between the front end and the hash engine.
// Depends on tth_pkg.
module tth_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tth_pkg::tth_char_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output tth_pkg::tth_char_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tth_pkg::tth_char_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/tth_back.sv
// Back end: folds queued bytes into the running djb2 hash and emits finished tokens.
// Depends on tth_pkg.
module tth_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               char_valid,
  input  tth_pkg::tth_char_t char_in,
  output logic               char_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output tth_pkg::tth_out_t  out_data
);

  logic        inside_r, inside_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  tth_pkg::tth_out_t out_data_r, out_data_nxt;

  logic        emit;
  logic [7:0]  base_len;
  logic [31:0] base_hash;
  logic [7:0]  tok_len;
  logic [31:0] tok_hash;

  // Take a byte whenever the output slot is free or drains this cycle.
  assign char_pop = char_valid && (!out_valid_r || !out_stall);

  always_comb begin
    base_len  = inside_r ? len_r : 8'd0;
    base_hash = inside_r ? hash_r : tth_pkg::HASH_SEED;
    tok_len   = base_len;
    tok_hash  = base_hash;
    if (char_in.is_word && (base_len < tth_pkg::MAX_LEN)) begin
      tok_hash = (base_hash << tth_pkg::HASH_SHIFT) + base_hash + {24'd0, char_in.ch};
      tok_len  = base_len + 8'd1;
    end
  end

  always_comb begin
    emit       = 1'b0;
    inside_nxt = inside_r;
    len_nxt    = len_r;
    hash_nxt   = hash_r;
    pos_nxt    = pos_r;
    if (char_pop) begin
      if (char_in.is_word) begin
        emit       = char_in.last;
        inside_nxt = !char_in.last;
        len_nxt    = char_in.last ? 8'd0 : tok_len;
        hash_nxt   = char_in.last ? tth_pkg::HASH_SEED : tok_hash;
      end else if (inside_r) begin
        emit       = 1'b1;
        inside_nxt = 1'b0;
        len_nxt    = 8'd0;
        hash_nxt   = tth_pkg::HASH_SEED;
        pos_nxt    = pos_r + 32'd1;
      end
      if (char_in.last) begin
        pos_nxt = 32'd0;
      end
    end
  end

  always_comb begin
    out_data_nxt                = out_data_r;
    out_valid_nxt               = out_valid_r && out_stall;
    if (char_pop) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      out_data_nxt.token_hash     = tok_hash;
      out_data_nxt.bucket_index   = 12'(tok_hash & tth_pkg::BUCKET_MASK);
      out_data_nxt.token_length   = tok_len;
      out_data_nxt.token_position = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r    <= 1'b0;
      len_r       <= 8'd0;
      hash_r      <= tth_pkg::HASH_SEED;
      pos_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      inside_r    <= inside_nxt;
      len_r       <= len_nxt;
      hash_r      <= hash_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/text_tokenizer_djb2_hash_top.sv
// Top level of the streaming tokenizer with djb2 token hashing.
// Depends on tth_pkg, tth_front, tth_queue and tth_back.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | tth_in_t  (text_byte, text_end)
//   out     | output    | out_valid/out_stall | tth_out_t (hash, bucket, length, pos)
//
// One byte per cycle sustained while out_stall is low. With an empty queue, the byte that
// ends a token is written into the queue entry; the back end then pops it and registers
// the token result in its output register, from which it is offered.
// The hash engine folds each word byte, up to MAX_LEN, into its state (shift-add by 33).
// Reset is synchronous and clears the queue, token state and output valid.
// An output stall fills the QUEUE_DEPTH-entry queue; in_stall rises when it is full.
module text_tokenizer_djb2_hash_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tth_pkg::tth_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tth_pkg::tth_out_t out_data
);

  tth_pkg::tth_char_t front_char;
  tth_pkg::tth_char_t head_char;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;
  logic               q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  tth_front u_front (
    .in_data  (in_data),
    .char_out (front_char)
  );

  tth_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_char),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_char)
  );

  tth_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (q_not_empty),
    .char_in    (head_char),
    .char_pop   (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: sv/tth_checker.sv
// Port-level checker for the tokenizer top level, attached by bind.
// Depends on tth_pkg and text_tokenizer_djb2_hash_top.
module tth_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tth_pkg::tth_out_t out_data
);

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.token_length != 8'd0) &&
                  (out_data.token_length <= tth_pkg::MAX_LEN))
    else $error("token length out of range");

  a_bucket_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.bucket_index == out_data.token_hash[11:0])
    else $error("bucket index does not match hash");

  // The queue only fills through accepted transactions.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("in_stall rose without an accepted transaction");

endmodule

bind text_tokenizer_djb2_hash_top tth_checker u_tth_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
